// ===== rtl/core/ycr_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, pipeline stage numbering and control struct for the
// limited-range ycbcr to rgb converter; no dependencies
package ycr_pkg;

  // sample and output formats
  localparam int IN_W         = 12;
  localparam int CFG_W        = 16;
  localparam int OUT_BITS_DEF = 10;

  // sample_scale reset value and the offset it implies
  localparam int SCALE_RESET = 1023;
  localparam int OFF_W       = CFG_W + 1;
  localparam logic [OFF_W-1:0] OFF_RESET = OFF_W'((SCALE_RESET + 1) / 2);

  // internal widths
  localparam int NUM_W  = 18;  // offset and bias corrected sample
  localparam int NORM_W = 18;  // q1.16 normalized value, signed
  localparam int X_W    = 24;  // dividend of the constant division
  localparam int Q_W    = 16;  // quotient
  localparam int PROD_W = 32;  // q.30 matrix term
  localparam int SUM_W  = 33;  // q.30 matrix sum

  // q1.16 limits
  localparam logic signed [NORM_W-1:0] FRAC_ONE  = NORM_W'(65536);
  localparam logic signed [NORM_W-1:0] FRAC_HALF = NORM_W'(32768);

  // bt.709 coefficients in q2.14
  localparam int COEF_SHIFT = 14;
  localparam logic signed [15:0] COEF_R_CR = 16'sd25802;
  localparam logic signed [15:0] COEF_G_CB = -16'sd3069;
  localparam logic signed [15:0] COEF_G_CR = -16'sd7670;
  localparam logic signed [15:0] COEF_B_CB = 16'sd30403;
  localparam int Q30_SHIFT = 30;

  // limited-range levels at 8 bits, scaled by 2^(OUT_BITS-8)
  localparam int LUMA_FOOT   = 16;
  localparam int LUMA_SPAN   = 219;
  localparam int CHROMA_MID  = 128;
  localparam int CHROMA_HALF = 112;
  localparam int CHROMA_SPAN = 224;

  // pipeline stages
  localparam int NUM_STAGES = 6;
  localparam int ST_NUM   = 0;  // offset and bias
  localparam int ST_RECIP = 1;  // reciprocal multiply
  localparam int ST_NORM  = 2;  // quotient fix-up and clipping
  localparam int ST_PROD  = 3;  // matrix products
  localparam int ST_SUM   = 4;  // matrix sums
  localparam int ST_OUT   = 5;  // scale, clip, output register

  typedef struct packed {
    logic [NUM_STAGES-1:0] ld;   // stage register may load this cycle
    logic [NUM_STAGES-1:0] vld;  // stage register holds a live beat
  } ycr_pipe_t;

endpackage

// ===== rtl/core/ycr_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces: pixel input, rgb output, config write
// depends on ycr_pkg
interface ycr_pix_if import ycr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] luma;
  logic signed [IN_W-1:0] chroma_blue;
  logic signed [IN_W-1:0] chroma_red;

  modport source (output valid, luma, chroma_blue, chroma_red, input ready);
  modport sink   (input valid, luma, chroma_blue, chroma_red, output ready);
endinterface

interface ycr_rgb_if import ycr_pkg::*; #(parameter int OUT_BITS = OUT_BITS_DEF) ();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] red;
  logic [OUT_BITS-1:0] green;
  logic [OUT_BITS-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface ycr_cfg_if import ycr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/ycbcr_to_rgb_limited_range.sv =====
`timescale 1ns / 1ps
// Limited-range BT.709 YCbCr to RGB converter, one pixel per clock. Each
// accepted beat carries three zero-centred 12-bit samples; sample_scale sets
// an offset of (sample_scale+1)/2 that is added to every sample first. Luma
// and chroma are normalized to q1.16 against the limited-range levels
// (scaled by 2^(OUT_BITS-8)), run through the matrix with q2.14
// coefficients and scaled to 0..2^OUT_BITS-1 with clipping. The pipeline
// is six register stages deep, and with the sink ready a new beat is taken
// every cycle. Each stage holds while the one after it is stalled and fills
// when empty, so bubbles collapse and input is still taken while a result
// waits, until every stage holds a beat.
// Config writes are always accepted; write only while no pixel is in flight.
// Depends on ycr_pkg, ycr_if and the ycr_* submodules.
module ycbcr_to_rgb_limited_range import ycr_pkg::*; #(
  parameter int OUT_BITS = OUT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ycr_pix_if.sink   in_px,
  ycr_rgb_if.source out_rgb,
  ycr_cfg_if.sink   cfg_wr
);

  localparam int ND = 1 << (OUT_BITS - 8);
  localparam logic signed [NUM_W-1:0] Y_BIAS = NUM_W'(LUMA_FOOT * ND);
  localparam logic signed [NUM_W-1:0] C_BIAS = NUM_W'(CHROMA_MID * ND);

  // offset register, kept as (sample_scale+1)/2 rather than the raw scale
  logic [OFF_W-1:0] off_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= OFF_RESET;
    end else if (cfg_wr.valid) begin
      off_r <= OFF_W'((18'(cfg_wr.data) + 18'd1) >> 1);
    end
  end

  // stage control
  ycr_pipe_t pipe;

  ycr_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_px.valid),
    .out_ready (out_rgb.ready),
    .pipe      (pipe)
  );

  assign in_px.ready   = pipe.ld[ST_NUM];
  assign out_rgb.valid = pipe.vld[ST_OUT];

  // first stage: add the offset, remove the black level or chroma midpoint
  logic signed [NUM_W-1:0] off_s;
  logic signed [NUM_W-1:0] v_y, v_cb, v_cr;
  logic signed [NUM_W-1:0] num_y_r, num_cb_r, num_cr_r;

  always_comb begin
    off_s = signed'(NUM_W'(off_r));
    v_y   = NUM_W'(in_px.luma) + off_s;
    v_cb  = NUM_W'(in_px.chroma_blue) + off_s;
    v_cr  = NUM_W'(in_px.chroma_red) + off_s;
  end

  always_ff @(posedge clk) begin
    if (pipe.ld[ST_NUM]) begin
      num_y_r  <= v_y - Y_BIAS;
      num_cb_r <= v_cb - C_BIAS;
      num_cr_r <= v_cr - C_BIAS;
    end
  end

  // normalization, two stages per component
  logic signed [NORM_W-1:0] y_n, cb_n, cr_n;

  ycr_norm #(.OUT_BITS(OUT_BITS), .IS_CHROMA(1'b0)) u_norm_y (
    .clk  (clk),
    .pipe (pipe),
    .num  (num_y_r),
    .norm (y_n)
  );

  ycr_norm #(.OUT_BITS(OUT_BITS), .IS_CHROMA(1'b1)) u_norm_cb (
    .clk  (clk),
    .pipe (pipe),
    .num  (num_cb_r),
    .norm (cb_n)
  );

  ycr_norm #(.OUT_BITS(OUT_BITS), .IS_CHROMA(1'b1)) u_norm_cr (
    .clk  (clk),
    .pipe (pipe),
    .num  (num_cr_r),
    .norm (cr_n)
  );

  // matrix, scaling and output register
  ycr_matrix #(.OUT_BITS(OUT_BITS)) u_matrix (
    .clk   (clk),
    .pipe  (pipe),
    .y     (y_n),
    .cb    (cb_n),
    .cr    (cr_n),
    .red   (out_rgb.red),
    .green (out_rgb.green),
    .blue  (out_rgb.blue)
  );

endmodule

// ===== rtl/core/ycr_pipe_ctrl.sv =====
`timescale 1ns / 1ps
// per-stage valid bits and load enables for the converter pipeline
// depends on ycr_pkg
module ycr_pipe_ctrl import ycr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  output ycr_pipe_t pipe
);

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] ld;

  // a stage loads when empty or when its content moves on
  always_comb begin
    ld[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ld[i] = !vld_r[i] || ld[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (ld[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (ld[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign pipe.ld  = ld;
  assign pipe.vld = vld_r;

`ifndef ASSERT_OFF
  // full pipe with a stalled sink must refuse input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((&vld_r) && !out_ready) |-> !ld[0])
    else $error("input taken while pipeline full and stalled");

  // empty pipe always takes input
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(|vld_r) |-> ld[0])
    else $error("empty pipeline not ready");

  // a stalled output beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NUM_STAGES-1] && !out_ready) |=> vld_r[NUM_STAGES-1])
    else $error("output beat dropped while stalled");
`endif

endmodule

// ===== rtl/core/ycr_norm.sv =====
`timescale 1ns / 1ps
// normalizes one bias-corrected sample to q1.16 with clipping; the
// constant division is a reciprocal multiply and one fix-up step
// depends on ycr_pkg, driven by ycr_pipe_ctrl stage enables
module ycr_norm import ycr_pkg::*; #(
  parameter int OUT_BITS  = OUT_BITS_DEF,
  parameter bit IS_CHROMA = 1'b0
) (
  input  logic                     clk,
  input  ycr_pipe_t                pipe,
  input  logic signed [NUM_W-1:0]  num,
  output logic signed [NORM_W-1:0] norm
);

  localparam int K  = OUT_BITS - 8;
  localparam int ND = 1 << K;
  // x = |num| * 2^16 / nd, reduced by the common power of two
  localparam int D  = IS_CHROMA ? (CHROMA_SPAN / 32) : LUMA_SPAN;
  localparam int SH = IS_CHROMA ? (11 - K) : (16 - K);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / D);
  localparam logic signed [NUM_W-1:0] HI_LIM =
    NUM_W'(IS_CHROMA ? (CHROMA_HALF * ND) : (LUMA_SPAN * ND));
  localparam logic signed [NUM_W-1:0] LO_LIM =
    NUM_W'(IS_CHROMA ? -(CHROMA_HALF * ND) : 0);

  // reciprocal stage
  logic             lo_nxt, hi_nxt, neg_nxt;
  logic [NUM_W-1:0] mag;
  logic [X_W-1:0]   x_nxt;
  logic [55:0]      prod;
  logic             lo_r, hi_r, neg_r;
  logic [X_W-1:0]   x_r;
  logic [Q_W-1:0]   q0_r;

  always_comb begin
    lo_nxt  = (num <= LO_LIM);
    hi_nxt  = (num >= HI_LIM);
    neg_nxt = num[NUM_W-1];
    mag     = neg_nxt ? NUM_W'(-num) : NUM_W'(num);
    x_nxt   = X_W'(mag[Q_W-1:0]) << SH;
    prod    = 56'(x_nxt) * 56'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (pipe.ld[ST_RECIP]) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      neg_r <= neg_nxt;
      x_r   <= x_nxt;
      q0_r  <= prod[32 +: Q_W];
    end
  end

  // fix-up stage: the estimate is the quotient or one below
  logic [X_W-1:0]    rem;
  logic [Q_W-1:0]    q;
  logic [NORM_W-1:0] q_ext;
  logic signed [NORM_W-1:0] norm_nxt;
  logic signed [NORM_W-1:0] norm_r;

  always_comb begin
    rem   = x_r - X_W'(X_W'(q0_r) * X_W'(D));
    q     = (rem >= X_W'(D)) ? Q_W'(q0_r + Q_W'(1)) : q0_r;
    q_ext = NORM_W'(q);
    if (IS_CHROMA) begin
      if (hi_r) begin
        norm_nxt = FRAC_HALF;
      end else if (lo_r) begin
        norm_nxt = -FRAC_HALF;
      end else begin
        norm_nxt = neg_r ? -signed'(q_ext) : signed'(q_ext);
      end
    end else begin
      if (lo_r) begin
        norm_nxt = '0;
      end else if (hi_r) begin
        norm_nxt = FRAC_ONE;
      end else begin
        norm_nxt = signed'(q_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.ld[ST_NORM]) begin
      norm_r <= norm_nxt;
    end
  end

  assign norm = norm_r;

`ifndef ASSERT_OFF
  // reciprocal estimate off by at most one
  a_recip_err: assert property (@(posedge clk)
    (pipe.vld[ST_RECIP] && !lo_r && !hi_r) |-> (rem < X_W'(2 * D)))
    else $error("reciprocal quotient estimate out of range");

  // normalized value inside its clip range
  a_norm_range: assert property (@(posedge clk)
    pipe.vld[ST_NORM] |->
      (IS_CHROMA ? (norm_r >= -FRAC_HALF && norm_r <= FRAC_HALF)
                 : (norm_r >= 0 && norm_r <= FRAC_ONE)))
    else $error("normalized sample outside clip range");
`endif

endmodule

// ===== rtl/core/ycr_matrix.sv =====
`timescale 1ns / 1ps
// bt.709 matrix on q1.16 inputs, then scale to the output range and clip
// depends on ycr_pkg, driven by ycr_pipe_ctrl stage enables
module ycr_matrix import ycr_pkg::*; #(
  parameter int OUT_BITS = OUT_BITS_DEF
) (
  input  logic                     clk,
  input  ycr_pipe_t                pipe,
  input  logic signed [NORM_W-1:0] y,
  input  logic signed [NORM_W-1:0] cb,
  input  logic signed [NORM_W-1:0] cr,
  output logic [OUT_BITS-1:0]      red,
  output logic [OUT_BITS-1:0]      green,
  output logic [OUT_BITS-1:0]      blue
);

  localparam int SC_W = SUM_W + OUT_BITS;
  localparam logic [OUT_BITS-1:0] MAXV = OUT_BITS'((1 << OUT_BITS) - 1);

  // product stage
  logic signed [NORM_W+15:0] p_rcr, p_gcb, p_gcr, p_bcb;
  logic signed [PROD_W-1:0]  yb_r, p_rcr_r, p_gcb_r, p_gcr_r, p_bcb_r;

  always_comb begin
    p_rcr = cr * COEF_R_CR;
    p_gcb = cb * COEF_G_CB;
    p_gcr = cr * COEF_G_CR;
    p_bcb = cb * COEF_B_CB;
  end

  always_ff @(posedge clk) begin
    if (pipe.ld[ST_PROD]) begin
      yb_r    <= PROD_W'(y) <<< COEF_SHIFT;
      p_rcr_r <= PROD_W'(p_rcr);
      p_gcb_r <= PROD_W'(p_gcb);
      p_gcr_r <= PROD_W'(p_gcr);
      p_bcb_r <= PROD_W'(p_bcb);
    end
  end

  // sum stage
  logic signed [SUM_W-1:0] sr_r, sg_r, sb_r;

  always_ff @(posedge clk) begin
    if (pipe.ld[ST_SUM]) begin
      sr_r <= SUM_W'(yb_r) + SUM_W'(p_rcr_r);
      sg_r <= SUM_W'(yb_r) + SUM_W'(p_gcb_r) + SUM_W'(p_gcr_r);
      sb_r <= SUM_W'(yb_r) + SUM_W'(p_bcb_r);
    end
  end

  // floor(sum * maxv / 2^30), zero at or below zero, saturating
  function automatic logic [OUT_BITS-1:0] to_out(input logic signed [SUM_W-1:0] s);
    logic [SC_W-1:0] su;
    logic [SC_W-1:0] sc;
    logic [SC_W-1:0] t;
    su = SC_W'(unsigned'(s));
    sc = (su << OUT_BITS) - su;
    t  = sc >> Q30_SHIFT;
    if (s[SUM_W-1] || s == '0) begin
      return '0;
    end else if (t >= SC_W'(MAXV)) begin
      return MAXV;
    end else begin
      return t[OUT_BITS-1:0];
    end
  endfunction

  // output register
  logic [OUT_BITS-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (pipe.ld[ST_OUT]) begin
      red_r   <= to_out(sr_r);
      green_r <= to_out(sg_r);
      blue_r  <= to_out(sb_r);
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

// ===== rtl/core/ycr_matrix_note.sv =====
`timescale 1ns / 1ps
// holds no logic; the matrix and output scaling live in ycr_matrix.sv
// no dependencies

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for the limited-range ycbcr to rgb converter: random and
// directed pixel beats under source gaps and sink stalls, several scale settings
// depends on ycr_pkg, ycr_if and the converter rtl
module tb_top import ycr_pkg::*; ();

  localparam int OUT_BITS    = OUT_BITS_DEF;
  localparam int STALL_LIMIT = 5000;  // cycles with no beat anywhere before giving up
  localparam int LONG_HOLD   = 300;   // sink hold-off long enough to back up the input
  localparam int PHASE_BEATS = 58;
  localparam longint Q16_ONE = 65536;

  typedef struct packed {
    logic signed [IN_W-1:0] luma;
    logic signed [IN_W-1:0] cb;
    logic signed [IN_W-1:0] cr;
  } pixel_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] red;
    logic [OUT_BITS-1:0] green;
    logic [OUT_BITS-1:0] blue;
  } rgb_t;

  // sink ready patterns, one picked per window
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_SPARSE} sink_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ycr_pix_if                       px_if ();
  ycr_rgb_if #(.OUT_BITS(OUT_BITS)) rgb_if ();
  ycr_cfg_if                       cfg_if ();

  ycbcr_to_rgb_limited_range #(.OUT_BITS(OUT_BITS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_px   (px_if),
    .out_rgb (rgb_if),
    .cfg_wr  (cfg_if)
  );

  // bench copy of the one register
  logic [CFG_W-1:0] scale_model = CFG_W'(SCALE_RESET);

  pixel_t pixel_backlog[$];   // beats waiting to be offered
  rgb_t   rgb_expected[$];    // predicted rgb, oldest first

  int mismatches  = 0;
  int idle_cycles = 0;

  // long sink hold-off request, raised by the sequence, served by the sink process
  bit long_stall_go   = 1'b0;
  bit long_stall_seen = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // conversion predictor
  // ---------------------------------------------------------------------------

  // luma to q1.16 against the limited-range foot and span, clipped to 0..1
  function automatic longint luma_q16(longint v, longint nd);
    longint num, den;
    num = v - LUMA_FOOT * nd;
    den = LUMA_SPAN * nd;
    if (num <= 0) return 0;
    if (num >= den) return Q16_ONE;
    return (num * Q16_ONE) / den;
  endfunction

  // chroma to q1.16 around mid level, clipped to -0.5..0.5; division truncates to zero
  function automatic longint chroma_q16(longint v, longint nd);
    longint num, lim;
    num = v - CHROMA_MID * nd;
    lim = CHROMA_HALF * nd;
    if (num >= lim) return Q16_ONE / 2;
    if (num <= -lim) return -(Q16_ONE / 2);
    return (num * Q16_ONE) / (CHROMA_SPAN * nd);
  endfunction

  // q.30 sum to output level: floor of sum * max / 2^30, clipped both ends
  function automatic logic [OUT_BITS-1:0] q30_to_level(longint sum);
    longint maxv, t;
    maxv = (longint'(1) << OUT_BITS) - 1;
    if (sum <= 0) return '0;
    t = (sum * maxv) >>> Q30_SHIFT;
    if (t > maxv) t = maxv;
    return t[OUT_BITS-1:0];
  endfunction

  function automatic rgb_t convert_pixel(pixel_t p, logic [CFG_W-1:0] scale);
    longint nd, off, y, cb, cr, ybase;
    rgb_t c;
    nd    = longint'(1) << (OUT_BITS - 8);
    off   = (longint'(scale) + 1) / 2;
    y     = luma_q16(longint'($signed(p.luma)) + off, nd);
    cb    = chroma_q16(longint'($signed(p.cb)) + off, nd);
    cr    = chroma_q16(longint'($signed(p.cr)) + off, nd);
    ybase = y * (longint'(1) << COEF_SHIFT);
    c.red   = q30_to_level(ybase + cr * longint'(COEF_R_CR));
    c.green = q30_to_level(ybase + cb * longint'(COEF_G_CB) + cr * longint'(COEF_G_CR));
    c.blue  = q30_to_level(ybase + cb * longint'(COEF_B_CB));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // pixel source: bursts of random length with random gaps in between
  // ---------------------------------------------------------------------------
  pixel_t px_cur;
  bit     px_pending = 1'b0;  // a beat is offered or about to be
  int     burst_left = 0;
  int     gap_left   = 0;

  always @(posedge clk) begin
    logic v_nxt;
    if (!rst_n) begin
      px_if.valid <= 1'b0;
    end else begin
      v_nxt = px_if.valid;
      // beat taken at this edge: predict it with the register as it stands
      if (px_if.valid && px_if.ready) begin
        rgb_expected.insert(rgb_expected.size(), convert_pixel(px_cur, scale_model));
        v_nxt = 1'b0;
      end
      if (!v_nxt) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_backlog.size() > 0) begin
          px_cur = pixel_backlog.pop_front();
          v_nxt  = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 48);
          burst_left--;
          // about a third of the bursts run straight into the next one
          if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
      px_pending = v_nxt;
      // valid stays high across back-to-back beats; one assignment per edge
      px_if.valid       <= v_nxt;
      px_if.luma        <= px_cur.luma;
      px_if.chroma_blue <= px_cur.cb;
      px_if.chroma_red  <= px_cur.cr;
    end
  end

  // ---------------------------------------------------------------------------
  // rgb sink: ready pattern per window, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  sink_mode_t sink_mode = SINK_OPEN;
  int         win_left  = 0;
  int         hold_left = 0;

  always @(posedge clk) begin
    logic r_nxt;
    if (!rst_n) begin
      rgb_if.ready <= 1'b0;
    end else begin
      if (long_stall_go && !long_stall_seen) begin
        long_stall_seen = 1'b1;
        hold_left       = LONG_HOLD;
      end
      if (win_left == 0) begin
        win_left  = $urandom_range(16, 96);
        sink_mode = sink_mode_t'($urandom_range(0, 3));
      end else begin
        win_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        r_nxt = 1'b0;
      end else begin
        case (sink_mode)
          SINK_OPEN:   r_nxt = 1'b1;
          SINK_COIN:   r_nxt = 1'($urandom_range(0, 1));
          SINK_MOSTLY: r_nxt = ($urandom_range(0, 7) != 0);
          default:     r_nxt = ($urandom_range(0, 3) == 0);
        endcase
      end
      rgb_if.ready <= r_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result check against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && rgb_if.valid && rgb_if.ready) begin
      if (rgb_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected rgb beat r=%0d g=%0d b=%0d", rgb_if.red, rgb_if.green,
                   rgb_if.blue);
      end else begin
        want = rgb_expected.pop_front();
        if (rgb_if.red !== want.red || rgb_if.green !== want.green ||
            rgb_if.blue !== want.blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("rgb mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue, rgb_if.red, rgb_if.green, rgb_if.blue);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no beat on any channel for too long ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (px_if.valid && px_if.ready) || (rgb_if.valid && rgb_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  function automatic void queue_pixel(int l, int b, int r);
    pixel_t p;
    p.luma = IN_W'(l);
    p.cb   = IN_W'(b);
    p.cr   = IN_W'(r);
    pixel_backlog.insert(pixel_backlog.size(), p);
  endfunction

  // sample whose offset value lands in [lo_lvl, hi_lvl]; full random if unreachable
  function automatic int pick_sample(int lo_lvl, int hi_lvl, int off);
    int lo, hi;
    lo = lo_lvl - off;
    hi = hi_lvl - off;
    if (lo < -2048) lo = -2048;
    if (hi > 2047) hi = 2047;
    if (lo > hi) return $urandom_range(0, 4095) - 2048;
    return lo + $urandom_range(0, hi - lo);
  endfunction

  // mostly pixels inside the unclipped window (a little past it), the rest raw noise
  function automatic void queue_random_phase(int n);
    int nd, off;
    nd  = 1 << (OUT_BITS - 8);
    off = (int'(scale_model) + 1) / 2;
    repeat (n) begin
      if ($urandom_range(0, 4) == 0)
        queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
      else
        queue_pixel(pick_sample(LUMA_FOOT * nd - 8, (LUMA_FOOT + LUMA_SPAN) * nd + 8, off),
                    pick_sample((CHROMA_MID - CHROMA_HALF) * nd - 8,
                                (CHROMA_MID + CHROMA_HALF) * nd + 8, off),
                    pick_sample((CHROMA_MID - CHROMA_HALF) * nd - 8,
                                (CHROMA_MID + CHROMA_HALF) * nd + 8, off));
    end
  endfunction

  // wait until the sender has drained and every prediction has been checked, then let the pipe settle
  task automatic wait_drained();
    while (pixel_backlog.size() != 0 || px_pending || rgb_expected.size() != 0)
      @(posedge clk);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  task automatic write_scale(logic [CFG_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    scale_model = v;
  endtask

  logic [CFG_W-1:0] scale_plan[$];

  initial begin
    // every input known from time zero
    px_if.valid       = 1'b0;
    px_if.luma        = '0;
    px_if.chroma_blue = '0;
    px_if.chroma_red  = '0;
    rgb_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    px_cur            = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats at the reset scale (offset 512): black foot, white top,
    // chroma clip edges one either side, sign extremes, all-ones and zero
    queue_pixel(0, 0, 0);
    queue_pixel(-2048, -2048, -2048);
    queue_pixel(2047, 2047, 2047);
    queue_pixel(-1, -1, -1);
    queue_pixel(-448, 0, 0);          // luma exactly at foot
    queue_pixel(-447, 0, 0);          // one above foot
    queue_pixel(428, 0, 0);           // luma exactly at white
    queue_pixel(427, 0, 0);           // one below white
    queue_pixel(0, 448, 448);         // chroma at upper clip
    queue_pixel(0, 447, 447);
    queue_pixel(0, -448, -448);       // chroma at lower clip
    queue_pixel(0, -447, -447);
    queue_pixel(428, 448, 448);       // sums past full scale
    queue_pixel(-448, -448, -448);    // sums below zero
    queue_pixel(-448, 448, -448);
    queue_pixel(428, -448, 448);
    queue_pixel(2047, -2048, 2047);
    queue_pixel(-2048, 2047, -2048);
    queue_pixel(12'h555, 12'haaa, 12'h555);
    queue_pixel(12'haaa, 12'h555, 12'haaa);
    wait_drained();

    // scale settings: extremes, odd/even around the reset value, a few random
    scale_plan = '{16'd0, 16'hffff, 16'd1, 16'd1022, 16'd1024, 16'd2047, 16'd4095,
                   16'd600, 16'd0, 16'd1023};
    scale_plan.insert(8, CFG_W'($urandom_range(0, 4200)));
    scale_plan.insert(9, CFG_W'($urandom_range(0, 65535)));

    foreach (scale_plan[i]) begin
      write_scale(scale_plan[i]);
      queue_random_phase(i == 0 ? PHASE_BEATS / 2 : PHASE_BEATS);
      // third setting: hold the sink off while the source keeps offering
      if (i == 2) long_stall_go = 1'b1;
      // source pauses here until the phase has fully come out
      wait_drained();
    end

    repeat (4 * NUM_STAGES) @(posedge clk);
    if (mismatches == 0 && rgb_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
